>>> hdl/rwc_pkg.sv
// Shared constants, types and the tap selection function for the window convolution.
package rwc_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = 12;
   localparam int KERNEL_SIDE = 5;
   localparam int LINES       = KERNEL_SIDE - 1;
   localparam int PIX_BITS    = 24;
   localparam int CHAN_BITS   = 8;
   localparam int CHANNELS    = 3;
   localparam int COEF_BITS   = 12;
   localparam int FRAC_BITS   = COEF_BITS - 2;
   localparam int TAPS        = KERNEL_SIDE * KERNEL_SIDE;
   localparam int COEF_WORDS  = 5;
   localparam int WORD_BITS   = 60;
   localparam int COLV_BITS   = KERNEL_SIDE * PIX_BITS;
   localparam int LS_BITS     = LINES * PIX_BITS;
   localparam int PROD_BITS   = COEF_BITS + CHAN_BITS + 1;
   localparam int CSUM_BITS   = PROD_BITS + 3;
   localparam int TOTAL_BITS  = CSUM_BITS + 3;
   localparam int RES_BITS    = CHANNELS * CHAN_BITS + 2;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam logic [2:0] CSR_RADIUS = 3'd0;
   localparam logic [2:0] CSR_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_COEF0  = 3'd2;
   localparam logic [2:0] CSR_COEF1  = 3'd3;
   localparam logic [2:0] CSR_COEF2  = 3'd4;
   localparam logic [2:0] CSR_COEF3  = 3'd5;
   localparam logic [2:0] CSR_COEF4  = 3'd6;

   typedef struct packed {
      logic shift;
      logic fill;
   } cell_ctrl_type;

   // Tap for window row/column under radius r; positions outside the kernel give zero.
   function automatic logic signed [COEF_BITS-1:0] tap_at(
      input logic [TAPS*COEF_BITS-1:0] flat, input logic [1:0] r,
      input int row, input int col);
      int s;
      int base;
      int t;
      logic signed [COEF_BITS-1:0] v;
      s    = 2 * int'(r) + 1;
      base = KERNEL_SIDE - s;
      v    = '0;
      if (row >= base && col >= base) begin
         t = (row - base) * s + (col - base);
         v = flat[t*COEF_BITS +: COEF_BITS];
      end
      return v;
   endfunction

endpackage

>>> hdl/rwc_line_store.sv
// Line store memory: previous rows packed per column, registered read with write forwarding.
module rwc_line_store (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [rwc_pkg::COL_BITS-1:0]      rd_addr,
   input  logic                              wr_en,
   input  logic [rwc_pkg::COL_BITS-1:0]      wr_addr,
   input  logic [rwc_pkg::LS_BITS-1:0]       wr_data,
   output logic [rwc_pkg::LS_BITS-1:0]       rd_data
);
   logic [rwc_pkg::LS_BITS-1:0] mem [rwc_pkg::MAX_WIDTH];
   logic [rwc_pkg::LS_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // take the word being written this cycle
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/rwc_cell.sv
// Window cell: one column of the pixel window, its products and its column sums.
module rwc_cell (
   input  logic                                        clock,
   input  rwc_pkg::cell_ctrl_type                      ctrl,
   input  logic [rwc_pkg::COLV_BITS-1:0]               new_col,
   input  logic [rwc_pkg::COLV_BITS-1:0]               nbr_col,
   input  logic [rwc_pkg::KERNEL_SIDE*rwc_pkg::COEF_BITS-1:0] coefs,
   output logic [rwc_pkg::COLV_BITS-1:0]               col_out,
   output logic [rwc_pkg::CHANNELS*rwc_pkg::CSUM_BITS-1:0] csum
);
   logic [rwc_pkg::COLV_BITS-1:0] win_ff;
   logic signed [rwc_pkg::PROD_BITS-1:0] prod_in [rwc_pkg::KERNEL_SIDE][rwc_pkg::CHANNELS];
   logic signed [rwc_pkg::PROD_BITS-1:0] prod_ff [rwc_pkg::KERNEL_SIDE][rwc_pkg::CHANNELS];
   logic [rwc_pkg::CHANNELS*rwc_pkg::CSUM_BITS-1:0] csum_in;
   logic [rwc_pkg::CHANNELS*rwc_pkg::CSUM_BITS-1:0] csum_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         win_ff <= ctrl.fill ? new_col : nbr_col;
      end
   end

   always_comb begin
      logic signed [rwc_pkg::CHAN_BITS:0]    px;
      logic signed [rwc_pkg::COEF_BITS-1:0]  cf;
      for (int i = 0; i < rwc_pkg::KERNEL_SIDE; i++) begin
         for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
            px = {1'b0, win_ff[i*rwc_pkg::PIX_BITS + c*rwc_pkg::CHAN_BITS +: rwc_pkg::CHAN_BITS]};
            cf = coefs[i*rwc_pkg::COEF_BITS +: rwc_pkg::COEF_BITS];
            prod_in[i][c] = rwc_pkg::PROD_BITS'(px) * rwc_pkg::PROD_BITS'(cf);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      csum_ff <= csum_in;
   end

   always_comb begin
      logic signed [rwc_pkg::CSUM_BITS-1:0] acc;
      for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
         acc = '0;
         for (int i = 0; i < rwc_pkg::KERNEL_SIDE; i++) begin
            acc = acc + rwc_pkg::CSUM_BITS'(prod_ff[i][c]);
         end
         csum_in[c*rwc_pkg::CSUM_BITS +: rwc_pkg::CSUM_BITS] = acc;
      end
   end

   assign col_out = win_ff;
   assign csum    = csum_ff;
endmodule

>>> hdl/rwc_out_fifo.sv
// Result queue in front of the output channel.
module rwc_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [rwc_pkg::RES_BITS-1:0]  push_data,
   input  logic                          pop,
   output logic                          valid,
   output logic [rwc_pkg::RES_BITS-1:0]  data
);
   logic [rwc_pkg::RES_BITS-1:0] slot_ff [rwc_pkg::FIFO_DEPTH];
   logic [rwc_pkg::FIFO_AW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [rwc_pkg::FIFO_AW:0]    cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (rwc_pkg::FIFO_AW+1)'(push) - (rwc_pkg::FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

   assign valid = cnt_ff != '0;
   assign data  = slot_ff[rp_ff];
endmodule

>>> hdl/rgb_window_convolution.sv
// Top level of the streaming 5x5 blue/green/red window convolution.
// Takes one pixel per clock while the input is not held. A row end holds the input for R
// further window steps (R = radius) while the window steps over the repeated edge pixel,
// and a result queue with no room left for another result holds it too. An eight-word
// result queue absorbs output stalls. Previous rows live in a 2048 x 96-bit memory, one
// column per word, with no clearing pass after reset.
module rgb_window_convolution (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_blue, in_green, in_red
   input  logic        req_tuser,   // frame_start
   input  logic        req_tlast,   // row_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_blue, out_green, out_red
   output logic        rsp_tuser,   // out_row_end
   output logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data
);
   localparam int CB = rwc_pkg::COL_BITS;
   localparam int WB = rwc_pkg::WIDTH_BITS;
   localparam int KS = rwc_pkg::KERNEL_SIDE;
   localparam int PB = rwc_pkg::PIX_BITS;

   // configuration
   logic [1:0]  radius_ff;
   logic [WB-1:0] lwidth_ff;
   logic [rwc_pkg::WORD_BITS-1:0] coef_ff [rwc_pkg::COEF_WORDS];
   logic [rwc_pkg::TAPS*rwc_pkg::COEF_BITS-1:0] coef_flat;
   logic [1:0]  r;
   logic [WB-1:0] width_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 2'd1;
         lwidth_ff <= WB'(640);
         for (int w = 0; w < rwc_pkg::COEF_WORDS; w++) begin
            coef_ff[w] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rwc_pkg::CSR_RADIUS: radius_ff  <= csr_data[1:0];
            rwc_pkg::CSR_WIDTH:  lwidth_ff  <= csr_data[WB-1:0];
            rwc_pkg::CSR_COEF0:  coef_ff[0] <= csr_data;
            rwc_pkg::CSR_COEF1:  coef_ff[1] <= csr_data;
            rwc_pkg::CSR_COEF2:  coef_ff[2] <= csr_data;
            rwc_pkg::CSR_COEF3:  coef_ff[3] <= csr_data;
            rwc_pkg::CSR_COEF4:  coef_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      r = (radius_ff == 2'd3) ? 2'd2 : radius_ff;
      if (lwidth_ff == '0) begin
         width_eff = WB'(1);
      end else if (lwidth_ff > WB'(rwc_pkg::MAX_WIDTH)) begin
         width_eff = WB'(rwc_pkg::MAX_WIDTH);
      end else begin
         width_eff = lwidth_ff;
      end
      for (int w = 0; w < rwc_pkg::COEF_WORDS; w++) begin
         coef_flat[w*rwc_pkg::WORD_BITS +: rwc_pkg::WORD_BITS] = coef_ff[w];
      end
   end

   // input stage: counters and line store read
   logic [CB-1:0] col_ff, col_in, col_a;
   logic [2:0]    rows_ff, rows_in, rows_a;
   logic          last_a, active_a, accept;

   // sequencing stage
   logic          s1_valid_ff, s1_valid_in;
   logic [PB-1:0] s1_pix_ff;
   logic [CB-1:0] s1_col_ff;
   logic          s1_last_ff, s1_active_ff;
   logic [1:0]    step_ff, step_in, final_step;
   logic          cur_emit, go, leave, credit_ok;
   logic [rwc_pkg::LS_BITS-1:0] ls_rd;
   logic [rwc_pkg::COLV_BITS-1:0] new_col;
   rwc_pkg::cell_ctrl_type ctrl;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      col_a    = req_tuser ? '0 : col_ff;
      rows_a   = req_tuser ? '0 : rows_ff;
      last_a   = req_tlast || ({1'b0, col_a} + WB'(1) >= width_eff);
      active_a = rows_a >= {r, 1'b0};
      col_in   = col_ff;
      rows_in  = rows_ff;
      if (accept) begin
         col_in  = last_a ? '0 : col_a + 1'b1;
         rows_in = (last_a && rows_a != 3'd7) ? rows_a + 1'b1 : rows_a;
      end
   end

   always_comb begin
      final_step = s1_last_ff ? r : 2'd0;
      cur_emit   = s1_active_ff && ({1'b0, s1_col_ff} + WB'(step_ff) >= WB'(r));
      go         = s1_valid_ff && (!cur_emit || credit_ok);
      leave      = go && step_ff == final_step;
      req_tready = !s1_valid_ff || leave;
      step_in    = step_ff;
      if (leave) begin
         step_in = 2'd0;
      end else if (go) begin
         step_in = step_ff + 1'b1;
      end
      s1_valid_in = accept ? 1'b1 : (leave ? 1'b0 : s1_valid_ff);
      ctrl.shift  = go;
      ctrl.fill   = step_ff == 2'd0 && s1_col_ff == '0;
      new_col[(KS-1)*PB +: PB] = s1_pix_ff;
      for (int i = 0; i < KS - 1; i++) begin
         new_col[i*PB +: PB] = ls_rd[(KS-2-i)*PB +: PB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         rows_ff     <= '0;
         s1_valid_ff <= 1'b0;
         step_ff     <= 2'd0;
      end else begin
         col_ff      <= col_in;
         rows_ff     <= rows_in;
         s1_valid_ff <= s1_valid_in;
         step_ff     <= step_in;
      end
      if (accept) begin
         s1_pix_ff    <= req_tdata;
         s1_col_ff    <= col_a;
         s1_last_ff   <= last_a;
         s1_active_ff <= active_a;
      end
   end

   rwc_line_store u_lines (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_a),
      .wr_en   (go && step_ff == 2'd0),
      .wr_addr (s1_col_ff),
      .wr_data ({ls_rd[rwc_pkg::LS_BITS-PB-1:0], s1_pix_ff}),
      .rd_data (ls_rd)
   );

   // window chain
   logic [rwc_pkg::COLV_BITS-1:0] col_bus [KS+1];
   logic [rwc_pkg::CHANNELS*rwc_pkg::CSUM_BITS-1:0] csum [KS];

   assign col_bus[KS] = new_col;

   for (genvar j = 0; j < KS; j++) begin : g_cell
      logic [KS*rwc_pkg::COEF_BITS-1:0] cell_coefs;
      always_comb begin
         for (int i = 0; i < KS; i++) begin
            cell_coefs[i*rwc_pkg::COEF_BITS +: rwc_pkg::COEF_BITS] =
               rwc_pkg::tap_at(coef_flat, r, i, j);
         end
      end
      rwc_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .new_col (new_col),
         .nbr_col (col_bus[j+1]),
         .coefs   (cell_coefs),
         .col_out (col_bus[j]),
         .csum    (csum[j])
      );
   end

   // result tracking through the product and column-sum stages
   logic       v1_ff, v2_ff, v3_ff;
   logic [1:0] f1_ff, f2_ff, f3_ff;
   logic       emit, pop;
   logic [rwc_pkg::FIFO_AW:0] cred_ff, cred_in;
   logic [rwc_pkg::RES_BITS-1:0] res_word;

   assign emit      = go && cur_emit;
   assign pop       = rsp_tvalid && rsp_tready;
   assign credit_ok = cred_ff < (rwc_pkg::FIFO_AW+1)'(rwc_pkg::FIFO_DEPTH);
   assign cred_in   = cred_ff + (rwc_pkg::FIFO_AW+1)'(emit) - (rwc_pkg::FIFO_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         cred_ff <= '0;
      end else begin
         v1_ff   <= emit;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         cred_ff <= cred_in;
      end
      // row end on the final edge step, run end on the item's last step
      f1_ff <= {s1_last_ff && step_ff == r, step_ff == final_step};
      f2_ff <= f1_ff;
      f3_ff <= f2_ff;
   end

   always_comb begin
      logic signed [rwc_pkg::TOTAL_BITS-1:0] tot;
      res_word[rwc_pkg::RES_BITS-1 -: 2] = f3_ff;
      for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
         tot = '0;
         for (int j = 0; j < KS; j++) begin
            tot = tot + rwc_pkg::TOTAL_BITS'($signed(
               csum[j][c*rwc_pkg::CSUM_BITS +: rwc_pkg::CSUM_BITS]));
         end
         if (tot[rwc_pkg::TOTAL_BITS-1]) begin
            res_word[c*8 +: 8] = 8'd0;
         end else if (|tot[rwc_pkg::TOTAL_BITS-2:rwc_pkg::FRAC_BITS+8]) begin
            res_word[c*8 +: 8] = 8'hFF;
         end else begin
            res_word[c*8 +: 8] = tot[rwc_pkg::FRAC_BITS +: 8];
         end
      end
   end

   logic [rwc_pkg::RES_BITS-1:0] head;

   rwc_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v3_ff),
      .push_data (res_word),
      .pop       (pop),
      .valid     (rsp_tvalid),
      .data      (head)
   );

   assign rsp_tdata = head[23:0];
   assign rsp_tlast = head[24];
   assign rsp_tuser = head[25];
endmodule

>>> hdl/rwc_checker.sv
// Port checker for the window convolution, bound to the top level.
module rwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [59:0] csr_data
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready right after reset");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("row end result is not the last of its run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result word changed");
endmodule

bind rgb_window_convolution rwc_checker u_rwc_checker (.*);

>>> dv/rgb_window_convolution_test.sv
// Self-checking testbench for the streaming blue/green/red window convolution.
module rgb_window_convolution_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rwc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 70;
   localparam int PRELOAD_COLS = 16;

   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       row_end;
      logic       run_last;
   } filtered_pixel_type;

   // Tracks the convolution state and queues the filtered pixels each input should produce.
   class filter_scoreboard;
      logic [PIX_BITS-1:0]  line_mem[LINES][MAX_WIDTH];
      logic [PIX_BITS-1:0]  window[KERNEL_SIDE][KERNEL_SIDE];
      logic [WORD_BITS-1:0] coef[COEF_WORDS];
      int unsigned          col_next;
      int unsigned          rows_done;
      int unsigned          radius;
      int unsigned          width;
      filtered_pixel_type   pending[$];

      function new();
         foreach (line_mem[i, j]) line_mem[i][j] = '0;
         foreach (window[i, j]) window[i][j] = '0;
         foreach (coef[i]) coef[i] = '0;
         col_next  = 0;
         rows_done = 0;
         radius    = 1;
         width     = 640;
      endfunction

      function void write_reg(logic [2:0] idx, logic [WORD_BITS-1:0] value);
         case (idx)
            CSR_RADIUS: radius = value[1:0];
            CSR_WIDTH:  width  = value[WIDTH_BITS-1:0];
            default: begin
               if (idx >= CSR_COEF0 && idx <= CSR_COEF4) coef[idx - CSR_COEF0] = value;
            end
         endcase
      endfunction

      function int kernel_tap(int t);
         logic signed [COEF_BITS-1:0] v;
         v = coef[t / 5][(t % 5) * COEF_BITS +: COEF_BITS];
         return int'(v);
      endfunction

      function void slide(logic [PIX_BITS-1:0] column[KERNEL_SIDE], bit fill);
         for (int i = 0; i < KERNEL_SIDE; i++) begin
            for (int j = 0; j < KERNEL_SIDE - 1; j++)
               window[i][j] = fill ? column[i] : window[i][j+1];
            window[i][KERNEL_SIDE-1] = column[i];
         end
      endfunction

      function filtered_pixel_type convolve(int unsigned r, bit row_last);
         filtered_pixel_type res;
         int s;
         int base;
         int sum;
         logic [7:0] chan[3];
         s    = 2 * r + 1;
         base = KERNEL_SIDE - s;
         for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int i = 0; i < s; i++)
               for (int j = 0; j < s; j++)
                  sum += int'(window[base+i][base+j][8*ch +: 8]) * kernel_tap(i * s + j);
            if (sum < 0) chan[ch] = 8'd0;
            else if ((sum >>> FRAC_BITS) > 255) chan[ch] = 8'd255;
            else chan[ch] = 8'(sum >>> FRAC_BITS);
         end
         res.blue     = chan[0];
         res.green    = chan[1];
         res.red      = chan[2];
         res.row_end  = row_last;
         res.run_last = 1'b0;
         return res;
      endfunction

      function void note_pixel(logic [PIX_BITS-1:0] pix, bit frame_start, bit row_end);
         logic [PIX_BITS-1:0] column[KERNEL_SIDE];
         filtered_pixel_type made[$];
         int unsigned r;
         int unsigned w;
         int unsigned c;
         bit last;
         bit active;
         if (frame_start) begin
            col_next  = 0;
            rows_done = 0;
         end
         r = (radius > 2) ? 2 : radius;
         w = (width < 1) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
         c = (col_next >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_next;
         column[KERNEL_SIDE-1] = pix;
         for (int d = 1; d < KERNEL_SIDE; d++) column[KERNEL_SIDE-1-d] = line_mem[d-1][c];
         for (int d = LINES - 1; d >= 1; d--) line_mem[d][c] = line_mem[d-1][c];
         line_mem[0][c] = pix;
         slide(column, c == 0);
         last   = row_end || (c + 1 >= w);
         active = rows_done >= 2 * r;
         if (active && c >= r) made = {made, convolve(r, last && r == 0)};
         if (last) begin
            for (int unsigned k = 1; k <= r; k++) begin
               slide(column, 1'b0);
               if (active && c + k >= r) made = {made, convolve(r, k == r)};
            end
            col_next = 0;
            if (rows_done < 7) rows_done++;
         end else begin
            col_next = c + 1;
         end
         if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
         pending = {pending, made};
      endfunction

      function bit check_pixel(logic [23:0] data, logic row_end, logic run_last,
                               output string why);
         filtered_pixel_type want;
         if (pending.size() == 0) begin
            why = $sformatf("unexpected word data=%h", data);
            return 1'b0;
         end
         want = pending.pop_front();
         if (data !== {want.red, want.green, want.blue} || row_end !== want.row_end ||
             run_last !== want.run_last) begin
            why = $sformatf("got b=%h g=%h r=%h row_end=%b last=%b, want %h %h %h %b %b",
                            data[7:0], data[15:8], data[23:16], row_end, run_last,
                            want.blue, want.green, want.red, want.row_end, want.run_last);
            return 1'b0;
         end
         return 1'b1;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [59:0] csr_data = '0;

   filter_scoreboard sb = new();
   int          fail_count = 0;
   int          cycles = 0;
   int          random_sent = 0;
   int          idle_mode = 0;   // 0: sender 20%, receiver 58%; 1: swapped; 2: no idling
   bit          out_of_reset = 1'b0;

   rgb_window_convolution u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report(string why);
      $display("mismatch at cycle %0d: %s", cycles, why);
      fail_count++;
   endtask

   // Check each accepted word, then pick next cycle's ready.
   always @(posedge clock) begin
      string why;
      if (out_of_reset && rsp_tvalid && rsp_tready)
         if (!sb.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast, why)) report(why);
      if (!out_of_reset) rsp_tready <= 1'b0;
      else if (idle_mode == 0) rsp_tready <= ($urandom_range(0, 99) >= 58);
      else if (idle_mode == 1) rsp_tready <= ($urandom_range(0, 99) >= 20);
      else rsp_tready <= 1'b1;
   end

   task automatic write_reg(logic [2:0] idx, logic [59:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
   endtask

   task automatic send_pixel(logic [23:0] pix, bit frame_start, bit row_end);
      int gap_pct;
      gap_pct = (idle_mode == 0) ? 20 : ((idle_mode == 1) ? 58 : 0);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= frame_start;
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(pix, frame_start, row_end);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int unsigned r, int unsigned w, logic [59:0] c[COEF_WORDS]);
      drain();
      write_reg(CSR_RADIUS, 60'(r));
      write_reg(CSR_WIDTH, 60'(w));
      for (int i = 0; i < COEF_WORDS; i++) write_reg(3'(CSR_COEF0 + i), c[i]);
      csr_valid <= 1'b0;
   endtask

   // mode 0: full range, 1: only 0 and 255; rows of len pixels, tlast may mark the last one
   task automatic send_frame(int rows, int len, int mode, bit with_start);
      logic [23:0] pix;
      for (int y = 0; y < rows; y++)
         for (int x = 0; x < len; x++) begin
            pix = 24'($urandom());
            if (mode == 1) pix = {{8{pix[0]}}, {8{pix[1]}}, {8{pix[2]}}};
            send_pixel(pix, with_start && x == 0 && y == 0,
                       (x == len - 1) ? ($urandom_range(0, 3) != 0 || len < sb.width) : 1'b0);
         end
   endtask

   function automatic logic [59:0] coef_word(int kind);
      logic [59:0] v;
      logic [11:0] t;
      for (int f = 0; f < 5; f++) begin
         case (kind)
            0: t = 12'($urandom());
            1: t = 12'($urandom_range(0, 160) - 32);
            default: t = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
         endcase
         v[12*f +: 12] = t;
      end
      return v;
   endfunction

   initial begin
      logic [59:0] c[COEF_WORDS];
      int r;
      int w;
      int len;
      int rows;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      out_of_reset <= 1'b1;
      @(posedge clock);

      // Fill every line memory column the stream can reach: four rows, radius 2, no output.
      foreach (c[i]) c[i] = '0;
      configure(3, PRELOAD_COLS, c);
      send_frame(4, PRELOAD_COLS, 0, 1'b1);

      // Directed: identity kernel on extreme pixels.
      idle_mode = 0;
      foreach (c[i]) c[i] = '0;
      c[0][48 +: 12] = 12'd1024;
      configure(1, 3, c);
      send_frame(3, 3, 1, 1'b1);
      // Zero width taken as one; negative tap drives the sum below zero.
      c[0] = 60'hFFF;
      configure(0, 0, c);
      send_pixel(24'hFF80FF, 1'b1, 1'b0);
      send_pixel(24'h010203, 1'b0, 1'b1);
      // Radius three taken as two, row narrower than the kernel, sum far above 255.
      foreach (c[i]) c[i] = {5{12'h7FF}};
      configure(3, 2, c);
      send_frame(5, 2, 1, 1'b1);

      while (random_sent < RANDOM_ITEMS) begin
         idle_mode = random_sent * 3 / RANDOM_ITEMS;
         r = $urandom_range(0, 3);
         w = ($urandom_range(0, 7) == 0) ? MAX_WIDTH : $urandom_range(1, 8);
         foreach (c[i]) c[i] = coef_word($urandom_range(0, 2) == 0 ? 0 : 1);
         if ($urandom_range(0, 9) == 0) foreach (c[i]) c[i] = coef_word(2);
         configure(r, w, c);
         for (int f = 0; f < 2; f++) begin
            len  = $urandom_range(1, (w > 8) ? 8 : w);
            rows = ((r > 2) ? 4 : 2 * r) + $urandom_range(1, 3);
            send_frame(rows, len, $urandom_range(0, 4) == 0, $urandom_range(0, 6) != 0);
            random_sent += len * rows;
            // Noise: a row of a different length or pixels with random flags.
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 6)) begin
                  send_pixel(24'($urandom()), $urandom_range(0, 9) == 0,
                             $urandom_range(0, 1) == 1);
                  random_sent++;
               end
         end
      end
      idle_mode = 2;
      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
